FILE: sv/bpp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the Boris pusher block.
// No dependencies; every other file imports this package.
package bpp_pkg;

  localparam int GRID_X_DEF = 14;
  localparam int GRID_Y_DEF = 14;
  localparam int GRID_Z_DEF = 14;

  localparam int ADDR_SPACE = 4096;
  localparam int NODE_W     = 12;
  localparam int ONE_Q      = 65536;
  localparam int HALF_Q     = 32768;
  localparam int FIELD_W    = 96;
  localparam int DIV_W      = 34;
  localparam int G_W        = 18;

  typedef logic signed [31:0] q_t;
  typedef logic signed [32:0] mop_t;
  typedef logic signed [65:0] prod_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COORD, ST_GATH, ST_GFIN, ST_FSQ, ST_BSQ, ST_DEN, ST_DIV,
    ST_VEL, ST_VB, ST_U, ST_UB, ST_NV, ST_NP
  } state_t;

  typedef enum logic [1:0] {
    MODE_LOAD_E = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_PUSH   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
    REG_INV_STEP_X, REG_INV_STEP_Y, REG_INV_STEP_Z,
    REG_HALF_QM_DT, REG_TIME_STEP
  } reg_idx_t;

  typedef struct packed {
    logic                start;
    logic [31:0]         den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_W-1:0]    quo;
  } div_rsp_t;

  localparam prod_t Q_MAX = 66'sd2147483647;
  localparam prod_t Q_MIN = -66'sd2147483648;

  // Clamp a wide signed value to the Q16.16 range.
  function automatic q_t sat66(input prod_t v);
    q_t r;
    if (v > Q_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Q_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic mop_t sx33(input q_t v);
    return {v[31], v};
  endfunction

  function automatic mop_t zx33(input logic [31:0] v);
    return {1'b0, v};
  endfunction

endpackage

FILE: sv/bpp_mul.sv
`timescale 1ns / 1ps
// Shared 33x33 signed multiplier with registered product.
// Depends on bpp_pkg.
module bpp_mul
  import bpp_pkg::*;
(
  input  logic  clk,
  input  mop_t  a,
  input  mop_t  b,
  output prod_t p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

FILE: sv/bpp_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider computing 2.0 (Q16.16) / den, one bit a cycle.
// Depends on bpp_pkg.
module bpp_div
  import bpp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [DIV_W-1:0] NUM = DIV_W'(1) << (DIV_W - 1);

  logic             busy_r, busy_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [31:0]      den_r, den_nxt;
  logic [32:0]      sh;
  logic             ge;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    sh       = {rem_r, quo_r[DIV_W-1]};
    ge       = sh >= {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(DIV_W);
      rem_nxt  = '0;
      quo_nxt  = NUM;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(sh - {1'b0, den_r}) : sh[31:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

FILE: sv/bpp_fmem.sv
`timescale 1ns / 1ps
// Single-port field store, one grid node of three Q16.16 values per word.
// Depends on bpp_pkg.
module bpp_fmem
  import bpp_pkg::*;
#(
  parameter int DEPTH = ADDR_SPACE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [AW-1:0]      addr,
  input  logic [FIELD_W-1:0] wdata,
  output logic [FIELD_W-1:0] rdata_r
);

  logic [FIELD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

FILE: sv/boris_particle_push_trilinear_top.sv
`timescale 1ns / 1ps
// Top level of the Boris particle pusher with trilinear E/B gather.
// Depends on bpp_pkg, bpp_mul, bpp_div and bpp_fmem.
//
// Load items (modes 0 and 1) write one grid node in the accept cycle and keep
// busy low. A push item holds busy while every product goes through one shared
// 33x33 multiplier, over 16 gather corners (a corner that lies off the grid is
// skipped), and while the bit-serial divider computes the rotation gain. The
// result is on the out_ ports when out_valid is high for exactly one cycle; it
// cannot be stalled, and a new item may be started in that same cycle.
module boris_particle_push_trilinear_top
  import bpp_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_mode,
  input  logic [NODE_W-1:0] in_node_index,
  input  q_t                in_field_x,
  input  q_t                in_field_y,
  input  q_t                in_field_z,
  input  q_t                in_pos_x,
  input  q_t                in_pos_y,
  input  q_t                in_pos_z,
  input  q_t                in_vel_x,
  input  q_t                in_vel_y,
  input  q_t                in_vel_z,
  output logic              out_valid,
  output q_t                out_new_pos_x,
  output q_t                out_new_pos_y,
  output q_t                out_new_pos_z,
  output q_t                out_new_vel_x,
  output q_t                out_new_vel_y,
  output q_t                out_new_vel_z,
  output logic              out_gather_fault,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int B_DIM [3] = '{GRID_X + 1, GRID_Y + 1, GRID_Z + 1};
  localparam int E_DIM [3] = '{GRID_X + 2, GRID_Y + 2, GRID_Z + 2};
  localparam int B_NODES = (GRID_X + 1) * (GRID_Y + 1) * (GRID_Z + 1);
  localparam int E_NODES = (GRID_X + 2) * (GRID_Y + 2) * (GRID_Z + 2);
  localparam int B_DEPTH = (B_NODES < ADDR_SPACE) ? B_NODES : ADDR_SPACE;
  localparam int E_DEPTH = (E_NODES < ADDR_SPACE) ? E_NODES : ADDR_SPACE;
  localparam int B_AW = $clog2(B_DEPTH);
  localparam int E_AW = $clog2(E_DEPTH);

  // configuration
  q_t          org_r [3];
  logic [31:0] inv_r [3];
  q_t          hqm_r;
  logic [30:0] ts_r;

  // control
  state_t      state_r, state_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        ph_r, ph_nxt;
  logic        sub_r, sub_nxt;
  logic [2:0]  cstep_r, cstep_nxt;
  logic        grid_r, grid_nxt;
  logic        out_valid_r, out_valid_nxt;

  // datapath
  q_t                 pos_r [3];
  q_t                 vel_r [3];
  logic signed [49:0] s_r [3];
  logic signed [51:0] acc_r [3];
  logic [16:0]        wt_r;
  logic               fault_r;
  q_t                 bf_r [3];
  q_t                 ef_r [3];
  q_t                 fsq_r;
  logic signed [33:0] tmp_r;
  logic [G_W-1:0]     g_r;
  q_t                 v_r [3];
  q_t                 vb_r [3];
  q_t                 u_r [3];
  q_t                 ub_r [3];
  q_t                 nv_r [3];
  q_t                 np_r [3];

  mop_t     mul_a, mul_b;
  prod_t    p_r;
  q_t       qp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               accept;
  logic               mem_re;
  logic [1:0]         ci, cj, ck;
  logic signed [32:0] dpos;
  logic signed [32:0] dmag;
  logic [31:0]        mag;
  logic [47:0]        pp;
  logic signed [49:0] s_new;
  logic signed [49:0] sg [3];
  logic signed [34:0] ix [3];
  logic [16:0]        w [3];
  logic [2:0]         inr;
  logic [31:0]        lin;
  logic               range_ok;
  logic               lin_ok;
  q_t                 fld [3];
  q_t                 tmp32;
  q_t                 bsq_q;
  q_t                 crs_a [3];
  logic               e_we, b_we;
  logic [FIELD_W-1:0] e_rd, b_rd, ld_data;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign qp        = sat66(p_r >>> 16);
  assign tmp32     = tmp_r[31:0];
  assign bsq_q     = sat66(66'(tmp_r));

  // cross product lanes: r[i] = a[j]*b[k] - a[k]*b[j]
  assign ci = idx_r[1:0];
  assign cj = (ci == 2'd2) ? 2'd0 : ci + 2'd1;
  assign ck = (ci == 2'd0) ? 2'd2 : ci - 2'd1;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      crs_a[a] = (state_r == ST_VB) ? v_r[a] : u_r[a];
    end
  end

  // grid coordinate magnitude for the current axis
  assign dpos  = 33'(pos_r[ci]) - 33'(org_r[ci]);
  assign dmag  = dpos[32] ? -dpos : dpos;
  assign mag   = dmag[31:0];
  assign pp    = p_r[63:16];
  assign s_new = dpos[32] ? -$signed({2'b00, pp}) : $signed({2'b00, pp});

  // corner of the current gather
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sg[a]  = s_r[a] + (grid_r ? 50'sd32768 : 50'sd0);
      ix[a]  = {sg[a][49], sg[a][49:16]} + {34'd0, idx_r[a]};
      w[a]   = idx_r[a] ? {1'b0, sg[a][15:0]} : 17'(ONE_Q) - {1'b0, sg[a][15:0]};
      inr[a] = !ix[a][34] &&
               (ix[a][33:0] < 34'(grid_r ? E_DIM[a] : B_DIM[a]));
    end
    lin = (32'(ix[0][8:0]) * 32'(grid_r ? E_DIM[1] : B_DIM[1]) + 32'(ix[1][8:0])) *
          32'(grid_r ? E_DIM[2] : B_DIM[2]) + 32'(ix[2][8:0]);
    range_ok = &inr;
    lin_ok   = lin < 32'(ADDR_SPACE);
    for (int a = 0; a < 3; a++) begin
      fld[a] = grid_r ? e_rd[32*a +: 32] : b_rd[32*a +: 32];
    end
  end

  // sequencer: next state and multiplier operands
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ph_nxt        = ph_r;
    sub_nxt       = sub_r;
    cstep_nxt     = cstep_r;
    grid_nxt      = grid_r;
    out_valid_nxt = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    mem_re        = 1'b0;
    div_req.start = 1'b0;
    div_req.den   = 32'(ONE_Q) + qp[31:0];
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_mode == MODE_PUSH) begin
          state_nxt = ST_COORD;
          idx_nxt   = '0;
          ph_nxt    = 1'b0;
        end
      end
      ST_COORD: begin
        mul_a  = zx33(mag);
        mul_b  = zx33(inv_r[ci]);
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (ci == 2'd2) begin
            state_nxt = ST_GATH;
            idx_nxt   = '0;
            cstep_nxt = '0;
            grid_nxt  = 1'b0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      ST_GATH: begin
        case (cstep_r)
          3'd0: begin
            if (range_ok && lin_ok) begin
              mul_a     = zx33(32'(w[0]));
              mul_b     = zx33(32'(w[1]));
              mem_re    = 1'b1;
              cstep_nxt = 3'd1;
            end else if (idx_r == 3'd7) begin
              state_nxt = ST_GFIN;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
          3'd1: begin
            mul_a     = zx33(32'(p_r[32:16]));
            mul_b     = zx33(32'(w[2]));
            cstep_nxt = 3'd2;
          end
          3'd2: begin
            mul_a     = zx33(32'(p_r[32:16]));
            mul_b     = sx33(fld[0]);
            cstep_nxt = 3'd3;
          end
          3'd3: begin
            mul_a     = zx33(32'(wt_r));
            mul_b     = sx33(fld[1]);
            cstep_nxt = 3'd4;
          end
          3'd4: begin
            mul_a     = zx33(32'(wt_r));
            mul_b     = sx33(fld[2]);
            cstep_nxt = 3'd5;
          end
          default: begin
            cstep_nxt = '0;
            if (idx_r == 3'd7) begin
              state_nxt = ST_GFIN;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
        endcase
      end
      ST_GFIN: begin
        idx_nxt   = '0;
        cstep_nxt = '0;
        ph_nxt    = 1'b0;
        if (!grid_r) begin
          grid_nxt  = 1'b1;
          state_nxt = ST_GATH;
        end else begin
          state_nxt = ST_FSQ;
        end
      end
      ST_FSQ: begin
        mul_a  = sx33(hqm_r);
        mul_b  = sx33(hqm_r);
        ph_nxt = !ph_r;
        if (ph_r) begin
          state_nxt = ST_BSQ;
          idx_nxt   = '0;
        end
      end
      ST_BSQ: begin
        mul_a  = sx33(bf_r[ci]);
        mul_b  = sx33(bf_r[ci]);
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (ci == 2'd2) begin
            state_nxt = ST_DEN;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      ST_DEN: begin
        mul_a  = sx33(bsq_q);
        mul_b  = sx33(fsq_r);
        ph_nxt = !ph_r;
        if (ph_r) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_VEL;
          idx_nxt   = '0;
          ph_nxt    = 1'b0;
        end
      end
      ST_VEL, ST_U: begin
        mul_a  = sx33(hqm_r);
        mul_b  = sx33((state_r == ST_VEL) ? ef_r[ci] : vb_r[ci]);
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (ci == 2'd2) begin
            state_nxt = (state_r == ST_VEL) ? ST_VB : ST_UB;
            idx_nxt   = '0;
            sub_nxt   = 1'b0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      ST_VB, ST_UB, ST_NV: begin
        if (state_r == ST_NV) begin
          mul_a = sub_r ? sx33(tmp32) : zx33(32'(g_r));
          mul_b = sub_r ? sx33(hqm_r) : sx33(ub_r[ci]);
        end else begin
          mul_a = sx33(sub_r ? crs_a[ck] : crs_a[cj]);
          mul_b = sx33(sub_r ? bf_r[cj] : bf_r[ck]);
        end
        ph_nxt = !ph_r;
        if (ph_r) begin
          sub_nxt = !sub_r;
          if (sub_r) begin
            if (ci == 2'd2) begin
              idx_nxt = '0;
              unique case (state_r)
                ST_VB:   state_nxt = ST_U;
                ST_UB:   state_nxt = ST_NV;
                default: state_nxt = ST_NP;
              endcase
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
        end
      end
      ST_NP: begin
        mul_a  = sx33(nv_r[ci]);
        mul_b  = zx33(32'(ts_r));
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (ci == 2'd2) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      ph_r        <= 1'b0;
      sub_r       <= 1'b0;
      cstep_r     <= '0;
      grid_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ph_r        <= ph_nxt;
      sub_r       <= sub_nxt;
      cstep_r     <= cstep_nxt;
      grid_r      <= grid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        org_r[a] <= '0;
        inv_r[a] <= 32'(ONE_Q);
      end
      hqm_r <= '0;
      ts_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X:   org_r[0] <= cfg_data;
        REG_ORIGIN_Y:   org_r[1] <= cfg_data;
        REG_ORIGIN_Z:   org_r[2] <= cfg_data;
        REG_INV_STEP_X: inv_r[0] <= cfg_data;
        REG_INV_STEP_Y: inv_r[1] <= cfg_data;
        REG_INV_STEP_Z: inv_r[2] <= cfg_data;
        REG_HALF_QM_DT: hqm_r    <= cfg_data;
        REG_TIME_STEP:  ts_r     <= cfg_data[30:0];
        default:        ts_r     <= ts_r;
      endcase
    end
  end

  // datapath writeback
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_mode == MODE_PUSH) begin
          pos_r   <= '{in_pos_x, in_pos_y, in_pos_z};
          vel_r   <= '{in_vel_x, in_vel_y, in_vel_z};
          fault_r <= 1'b0;
          for (int a = 0; a < 3; a++) begin
            acc_r[a] <= '0;
          end
        end
      end
      ST_COORD: begin
        if (ph_r) begin
          s_r[ci] <= s_new;
        end
      end
      ST_GATH: begin
        case (cstep_r)
          3'd0: begin
            if (!range_ok) begin
              fault_r <= 1'b1;
            end
          end
          3'd2: wt_r <= p_r[32:16];
          3'd3: acc_r[0] <= acc_r[0] + $signed(p_r[51:0]);
          3'd4: acc_r[1] <= acc_r[1] + $signed(p_r[51:0]);
          3'd5: acc_r[2] <= acc_r[2] + $signed(p_r[51:0]);
          default: wt_r <= wt_r;
        endcase
      end
      ST_GFIN: begin
        for (int a = 0; a < 3; a++) begin
          if (grid_r) begin
            ef_r[a] <= sat66(66'(acc_r[a] >>> 16));
          end else begin
            bf_r[a] <= sat66(66'(acc_r[a] >>> 16));
          end
          acc_r[a] <= '0;
        end
      end
      ST_FSQ: begin
        if (ph_r) begin
          fsq_r <= qp;
          tmp_r <= '0;
        end
      end
      ST_BSQ: begin
        if (ph_r) begin
          tmp_r <= tmp_r + 34'(qp);
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          g_r <= div_rsp.quo[G_W-1:0];
        end
      end
      ST_VEL: begin
        if (ph_r) begin
          v_r[ci] <= sat66(66'(vel_r[ci]) + 66'(qp));
        end
      end
      ST_VB, ST_UB: begin
        if (ph_r) begin
          if (!sub_r) begin
            tmp_r <= 34'(qp);
          end else if (state_r == ST_VB) begin
            vb_r[ci] <= sat66(66'(tmp32) - 66'(qp));
          end else begin
            ub_r[ci] <= sat66(66'(tmp32) - 66'(qp));
          end
        end
      end
      ST_U: begin
        if (ph_r) begin
          u_r[ci] <= sat66(66'(v_r[ci]) + 66'(qp));
        end
      end
      ST_NV: begin
        if (ph_r) begin
          if (!sub_r) begin
            tmp_r <= 34'(sat66(66'(qp) + 66'(ef_r[ci])));
          end else begin
            nv_r[ci] <= sat66(66'(v_r[ci]) + 66'(qp));
          end
        end
      end
      ST_NP: begin
        if (ph_r) begin
          np_r[ci] <= sat66(66'(pos_r[ci]) + 66'(qp));
        end
      end
      default: begin
        tmp_r <= tmp_r;
      end
    endcase
  end

  bpp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  bpp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // loads write in the accept cycle; nodes beyond the grid are dropped
  assign ld_data = {in_field_z, in_field_y, in_field_x};
  assign e_we = accept && in_mode == MODE_LOAD_E && 32'(in_node_index) < 32'(E_NODES);
  assign b_we = accept && in_mode == MODE_LOAD_B && 32'(in_node_index) < 32'(B_NODES);

  bpp_fmem #(
    .DEPTH (E_DEPTH),
    .AW    (E_AW)
  ) u_emem (
    .clk     (clk),
    .we      (e_we),
    .re      (mem_re && grid_r),
    .addr    (e_we ? in_node_index[E_AW-1:0] : lin[E_AW-1:0]),
    .wdata   (ld_data),
    .rdata_r (e_rd)
  );

  bpp_fmem #(
    .DEPTH (B_DEPTH),
    .AW    (B_AW)
  ) u_bmem (
    .clk     (clk),
    .we      (b_we),
    .re      (mem_re && !grid_r),
    .addr    (b_we ? in_node_index[B_AW-1:0] : lin[B_AW-1:0]),
    .wdata   (ld_data),
    .rdata_r (b_rd)
  );

  assign out_valid        = out_valid_r;
  assign out_new_pos_x    = np_r[0];
  assign out_new_pos_y    = np_r[1];
  assign out_new_pos_z    = np_r[2];
  assign out_new_vel_x    = nv_r[0];
  assign out_new_vel_y    = nv_r[1];
  assign out_new_vel_z    = nv_r[2];
  assign out_gather_fault = fault_r;

endmodule
